// File: rtl/distance_outlier_lock_filter_top_defines.svh
// Assertion macros shared by the filter RTL.
// Every check is sampled on clk and is switched off while rst is high.
`ifndef DISTANCE_OUTLIER_LOCK_FILTER_TOP_DEFINES_SVH
`define DISTANCE_OUTLIER_LOCK_FILTER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DOLF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DOLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dolf_pkg.sv
`timescale 1ns / 1ps

package dolf_pkg;

  localparam int DIST_WIDTH_DEF = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int CNT_W          = 4;

  localparam logic [15:0]      THRESHOLD_RST = 16'd320;
  localparam logic [CNT_W-1:0] LIMIT_RST     = 4'd2;
  localparam logic [CNT_W-1:0] LOCK_RST      = 4'd2;
  localparam logic [15:0]      CEILING_RST   = 16'd24000;
  localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_LOCK      = 2'd2,
    REG_CEILING   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]      reject_threshold;
    logic [CNT_W-1:0] reject_limit;
    logic [CNT_W-1:0] lock_count;
    logic [15:0]      first_ceiling;
  } cfg_t;

endpackage

// File: rtl/dolf_core.sv
`timescale 1ns / 1ps
`include "distance_outlier_lock_filter_top_defines.svh"

module dolf_core #(
  parameter int DIST_WIDTH = dolf_pkg::DIST_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dolf_pkg::cfg_t        cfg,
  input  logic                  step_en,
  input  logic [DIST_WIDTH-1:0] sample,
  output logic [DIST_WIDTH-1:0] filtered_next,
  output logic                  reliable_next,
  output logic                  accepted_next
);

  localparam int CMP_W = (DIST_WIDTH > 16) ? DIST_WIDTH : 16;

  logic [dolf_pkg::CNT_W-1:0] agree_count, agree_count_next;
  logic [dolf_pkg::CNT_W-1:0] reject_count, reject_count_next;
  logic [DIST_WIDTH-1:0]      reference_value, reference_value_next;
  logic [DIST_WIDTH-1:0]      output_value, output_value_next;
  logic                       reliable_flag, reliable_flag_next;
  logic                       acc;

  logic                       locked;
  logic [DIST_WIDTH-1:0]      diff_ref, diff_out;
  logic                       ref_ok, out_ok, below_ceiling;
  logic [dolf_pkg::CNT_W-1:0] rej_sat;
  logic                       drop;

  assign locked   = agree_count >= cfg.lock_count;
  assign diff_ref = (sample >= reference_value) ? sample - reference_value
                                                : reference_value - sample;
  assign diff_out = (sample >= output_value) ? sample - output_value
                                             : output_value - sample;
  assign ref_ok        = CMP_W'(diff_ref) < CMP_W'(cfg.reject_threshold);
  assign out_ok        = CMP_W'(diff_out) < CMP_W'(cfg.reject_threshold);
  assign below_ceiling = CMP_W'(sample) < CMP_W'(cfg.first_ceiling);

  // The rejection run saturates, so a limit at the counter top never drops.
  assign rej_sat = (reject_count == dolf_pkg::CNT_MAX) ? reject_count
                                                       : reject_count + 4'd1;
  assign drop    = rej_sat > cfg.reject_limit;

  always_comb begin
    agree_count_next     = agree_count;
    reject_count_next    = reject_count;
    reference_value_next = reference_value;
    output_value_next    = output_value;
    reliable_flag_next   = reliable_flag;
    acc                  = 1'b0;
    if (!locked) begin
      if (agree_count == '0) begin
        reference_value_next = sample;
        if (below_ceiling) begin
          agree_count_next = agree_count + 4'd1;
          acc              = 1'b1;
        end
      end else if (ref_ok) begin
        agree_count_next     = agree_count + 4'd1;
        reference_value_next = sample;
        acc                  = 1'b1;
        if (agree_count + 4'd1 == cfg.lock_count) begin
          output_value_next = sample;
          reject_count_next = '0;
        end
      end else if (drop) begin
        agree_count_next   = '0;
        reject_count_next  = '0;
        reliable_flag_next = 1'b0;
      end else begin
        reject_count_next = rej_sat;
      end
    end else begin
      reliable_flag_next = 1'b1;
      if (out_ok) begin
        reject_count_next    = '0;
        reference_value_next = sample;
        output_value_next    = sample;
        acc                  = 1'b1;
      end else if (drop) begin
        agree_count_next   = '0;
        reject_count_next  = '0;
        reliable_flag_next = 1'b0;
      end else begin
        reject_count_next = rej_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agree_count     <= '0;
      reject_count    <= '0;
      reference_value <= '0;
      output_value    <= '0;
      reliable_flag   <= 1'b0;
    end else if (step_en) begin
      agree_count     <= agree_count_next;
      reject_count    <= reject_count_next;
      reference_value <= reference_value_next;
      output_value    <= output_value_next;
      reliable_flag   <= reliable_flag_next;
    end
  end

  assign filtered_next = output_value_next;
  assign reliable_next = reliable_flag_next;
  assign accepted_next = acc;

  `DOLF_ASSERT_NEXT(a_ref_follows_accept, step_en && acc,
    reference_value == $past(sample), "accepted sample did not become the reference")
  `DOLF_ASSERT_NEXT(a_locked_step_reliable, step_en && locked,
    reliable_flag || (agree_count == '0 && reject_count == '0),
    "locked step left reliable low without dropping the lock")
  `DOLF_ASSERT_SAME(a_locked_accept_close, step_en && locked && acc,
    out_ok, "locked accept of a sample outside the threshold")

endmodule

// File: rtl/distance_outlier_lock_filter_top.sv
`timescale 1ns / 1ps
`include "distance_outlier_lock_filter_top_defines.svh"
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+---------------------------------------
// sample   | sample_valid / sample_ready | sample_distance
// result   | result_valid / result_ready | filtered_distance, reliable, accepted
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// Each sample transfer produces its result in the next cycle from the result register.
// A new sample is taken every cycle while the result side keeps up; the filter state
// update is one subtract, compare and counter step in the same cycle.
// When a result waits, sample_ready follows result_ready; cfg_ready is always high.
// rst (synchronous) clears the filter state and loads the register defaults.

module distance_outlier_lock_filter_top #(
  parameter int DIST_WIDTH = dolf_pkg::DIST_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  logic [DIST_WIDTH-1:0]            sample_distance,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [DIST_WIDTH-1:0]            filtered_distance,
  output logic                             reliable,
  output logic                             accepted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dolf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dolf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dolf_pkg::cfg_t        cfg;
  logic                  step_en;
  logic [DIST_WIDTH-1:0] filtered_next;
  logic                  reliable_next;
  logic                  accepted_next;

  assign cfg_ready    = 1'b1;
  assign sample_ready = !result_valid || result_ready;
  assign step_en      = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reject_threshold <= dolf_pkg::THRESHOLD_RST;
      cfg.reject_limit     <= dolf_pkg::LIMIT_RST;
      cfg.lock_count       <= dolf_pkg::LOCK_RST;
      cfg.first_ceiling    <= dolf_pkg::CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dolf_pkg::cfg_reg_t'(cfg_index))
        dolf_pkg::REG_THRESHOLD: cfg.reject_threshold <= cfg_data;
        dolf_pkg::REG_LIMIT:     cfg.reject_limit     <= cfg_data[dolf_pkg::CNT_W-1:0];
        dolf_pkg::REG_LOCK:      cfg.lock_count       <= cfg_data[dolf_pkg::CNT_W-1:0];
        dolf_pkg::REG_CEILING:   cfg.first_ceiling    <= cfg_data;
        default: ;
      endcase
    end
  end

  dolf_core #(
    .DIST_WIDTH(DIST_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step_en      (step_en),
    .sample       (sample_distance),
    .filtered_next(filtered_next),
    .reliable_next(reliable_next),
    .accepted_next(accepted_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_en) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      filtered_distance <= filtered_next;
      reliable          <= reliable_next;
      accepted          <= accepted_next;
    end
  end

  `DOLF_ASSERT_NEXT(a_sample_gives_result, sample_valid && sample_ready,
    result_valid, "sample transfer did not produce a result")

endmodule
